// ----- rtl/mcatc_pkg.sv -----
`timescale 1ns / 1ps

package mcatc_pkg;

  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned WINDOW_W    = 24;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned OUT_SENSORS = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd2048;
  localparam logic [WINDOW_W-1:0] WINDOW_RST    = 24'd2000;

  typedef enum logic [0:0] {
    FUNC_SAMPLE = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WINDOW    = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    logic [WINDOW_W-1:0] window;
  } cfg_t;

  typedef logic [OUT_SENSORS-1:0][SAMPLE_W-1:0] sample_vec_t;

  // Handshake between the input stage and the result stage.
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctrl_t;

endpackage

// ----- rtl/mcatc_in_reg.sv -----
`timescale 1ns / 1ps

module mcatc_in_reg #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mcatc_pkg::func_e          func_i,
  input  logic [TIME_BITS-1:0]      now_i,
  input  mcatc_pkg::sample_vec_t    samples_i,
  input  logic                      take_i,
  output mcatc_pkg::stage_ctrl_t    ctrl_o,
  output mcatc_pkg::func_e          func_o,
  output logic [TIME_BITS-1:0]      now_o,
  output mcatc_pkg::sample_vec_t    samples_o
);

  logic                   valid_q, valid_d;
  mcatc_pkg::func_e       func_q;
  logic [TIME_BITS-1:0]   now_q;
  mcatc_pkg::sample_vec_t samples_q;
  logic                   load;

  // Refill whenever the held item leaves or the stage is empty.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      func_q    <= func_i;
      now_q     <= now_i;
      samples_q <= samples_i;
    end
  end

  assign ctrl_o.valid = valid_q;
  assign ctrl_o.take  = valid_q && take_i;
  assign func_o       = func_q;
  assign now_o        = now_q;
  assign samples_o    = samples_q;

endmodule

// ----- rtl/mcatc_capture.sv -----
`timescale 1ns / 1ps

module mcatc_capture #(
  parameter int unsigned SENSOR_COUNT = 4,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              fire_i,
  input  mcatc_pkg::func_e                                  func_i,
  input  logic [TIME_BITS-1:0]                              now_i,
  input  mcatc_pkg::sample_vec_t                            samples_i,
  input  mcatc_pkg::cfg_t                                   cfg_i,
  output logic                                              done_o,
  output logic [mcatc_pkg::OUT_SENSORS-1:0][TIME_BITS-1:0]  arrival_o,
  output logic [mcatc_pkg::COUNT_W-1:0]                     count_o
);

  localparam int unsigned TW = $clog2(SENSOR_COUNT + 1);

  logic [SENSOR_COUNT-1:0]                          hit_q, hit_d, hit_new;
  logic [SENSOR_COUNT-1:0][TIME_BITS-1:0]           arr_q, arr_d;
  logic [SENSOR_COUNT-1:0][mcatc_pkg::SAMPLE_W-1:0] smp;
  logic [TIME_BITS-1:0]                             start_q, start_d, elapsed;
  logic                                             open_q, open_d;
  logic [TW-1:0]                                    tally_q, tally_d, add;
  logic                                             expire;
  logic [TW+mcatc_pkg::COUNT_W-1:0]                 tally_ext;

  // Sensors without an input port read as zero.
  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_smp
    if (i < mcatc_pkg::OUT_SENSORS) begin : g_port
      assign smp[i] = samples_i[i];
    end else begin : g_none
      assign smp[i] = '0;
    end
  end

  assign elapsed = now_i - start_q;
  assign expire  = open_q &&
                   (elapsed > {{(TIME_BITS-mcatc_pkg::WINDOW_W){1'b0}}, cfg_i.window});

  // Window expiry stamps every silent sensor, so sampling only matters otherwise.
  always_comb begin
    add = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      hit_new[i] = !hit_q[i] && (expire || (smp[i] >= cfg_i.threshold));
      add        = add + TW'(hit_new[i]);
    end
  end

  always_comb begin
    hit_d   = hit_q;
    arr_d   = arr_q;
    start_d = start_q;
    open_d  = open_q;
    tally_d = tally_q;
    done_o  = 1'b0;
    if (func_i == mcatc_pkg::FUNC_CLEAR) begin
      hit_d   = '0;
      arr_d   = '0;
      start_d = '0;
      open_d  = 1'b0;
      tally_d = '0;
    end else begin
      hit_d   = hit_q | hit_new;
      tally_d = tally_q + add;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (hit_new[i]) begin
          arr_d[i] = now_i;
        end
      end
      if (!open_q && (|hit_new)) begin
        open_d  = 1'b1;
        start_d = now_i;
      end
    end
    if (tally_d >= TW'(SENSOR_COUNT)) begin
      open_d = 1'b0;
      done_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= '0;
      arr_q   <= '0;
      start_q <= '0;
      open_q  <= 1'b0;
      tally_q <= '0;
    end else if (fire_i) begin
      hit_q   <= hit_d;
      arr_q   <= arr_d;
      start_q <= start_d;
      open_q  <= open_d;
      tally_q <= tally_d;
    end
  end

  for (genvar i = 0; i < mcatc_pkg::OUT_SENSORS; i++) begin : g_out
    if (i < SENSOR_COUNT) begin : g_live
      assign arrival_o[i] = arr_d[i];
    end else begin : g_absent
      assign arrival_o[i] = '0;
    end
  end

  assign tally_ext = {{mcatc_pkg::COUNT_W{1'b0}}, tally_d};
  assign count_o   = tally_ext[mcatc_pkg::COUNT_W-1:0];

endmodule

// ----- rtl/multi_channel_arrival_time_capture.sv -----
`timescale 1ns / 1ps

// Multi-channel arrival time capture.
// Input channel (in_valid_i / in_ready_o): one tick per transfer with a
// function code (sample tick or clear), the tick time and one reading per
// sensor. A silent sensor whose reading is at or above the threshold latches
// the tick time; the first hit opens a window, and once the elapsed time
// (modulo 2^TIME_BITS) exceeds the window length every silent sensor is
// stamped with the tick time. Expiry is checked before the readings.
// Output channel (out_valid_o / out_ready_i): one result per tick with the
// done flag, the four arrival times and the recorded count.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 threshold, index 1
// window length; other indexes are dropped. Always ready; write only when idle.
// A transfer loads the input register; the tick moves on into the result
// register once the result slot is free. The input channel takes one tick per
// cycle while results are taken, since the compare and stamping between the
// two registers are combinational.
// Reset: threshold 2048, window 2000, store and flags cleared, no result.
// Stall: a waiting result holds; the input register still takes one more
// tick, then in_ready_o drops until the result is taken.
module multi_channel_arrival_time_capture #(
  parameter int unsigned SENSOR_COUNT = 4,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [TIME_BITS-1:0]                now_time_i,
  input  logic [mcatc_pkg::SAMPLE_W-1:0]      sample_0_i,
  input  logic [mcatc_pkg::SAMPLE_W-1:0]      sample_1_i,
  input  logic [mcatc_pkg::SAMPLE_W-1:0]      sample_2_i,
  input  logic [mcatc_pkg::SAMPLE_W-1:0]      sample_3_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                event_done_o,
  output logic [TIME_BITS-1:0]                arrival_0_o,
  output logic [TIME_BITS-1:0]                arrival_1_o,
  output logic [TIME_BITS-1:0]                arrival_2_o,
  output logic [TIME_BITS-1:0]                arrival_3_o,
  output logic [mcatc_pkg::COUNT_W-1:0]       recorded_count_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mcatc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mcatc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  mcatc_pkg::cfg_t        cfg_q, cfg_d;
  mcatc_pkg::sample_vec_t samples_in, samples_s1;
  mcatc_pkg::stage_ctrl_t s1_ctrl;
  mcatc_pkg::func_e       func_s1;
  logic [TIME_BITS-1:0]   now_s1;
  logic                   take;

  logic                                             res_done;
  logic [mcatc_pkg::OUT_SENSORS-1:0][TIME_BITS-1:0] res_arr;
  logic [mcatc_pkg::COUNT_W-1:0]                    res_count;

  logic                                             out_valid_q, out_valid_d;
  logic                                             done_q;
  logic [mcatc_pkg::OUT_SENSORS-1:0][TIME_BITS-1:0] arr_q;
  logic [mcatc_pkg::COUNT_W-1:0]                    count_q;

  // ---------------------------------------------------------------------------
  // Configuration registers: decode the index, drop writes outside the map.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mcatc_pkg::CFG_THRESHOLD: cfg_d.threshold = cfg_data_i[mcatc_pkg::SAMPLE_W-1:0];
        mcatc_pkg::CFG_WINDOW:    cfg_d.window    = cfg_data_i[mcatc_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= mcatc_pkg::THRESHOLD_RST;
      cfg_q.window    <= mcatc_pkg::WINDOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. Advance the held tick whenever the result slot frees up.
  // ---------------------------------------------------------------------------
  assign samples_in = {sample_3_i, sample_2_i, sample_1_i, sample_0_i};
  assign take       = !out_valid_q || out_ready_i;

  mcatc_in_reg #(
    .TIME_BITS (TIME_BITS)
  ) u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .func_i    (mcatc_pkg::func_e'(func_i)),
    .now_i     (now_time_i),
    .samples_i (samples_in),
    .take_i    (take),
    .ctrl_o    (s1_ctrl),
    .func_o    (func_s1),
    .now_o     (now_s1),
    .samples_o (samples_s1)
  );

  // ---------------------------------------------------------------------------
  // Capture state and per-sensor compare; state commits on the same transfer
  // that loads the result register, so the next tick sees the committed state.
  // ---------------------------------------------------------------------------
  mcatc_capture #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .TIME_BITS   (TIME_BITS)
  ) u_capture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_ctrl.take),
    .func_i   (func_s1),
    .now_i    (now_s1),
    .samples_i(samples_s1),
    .cfg_i    (cfg_q),
    .done_o   (res_done),
    .arrival_o(res_arr),
    .count_o  (res_count)
  );

  // ---------------------------------------------------------------------------
  // Result register: hold while the receiver stalls.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_ctrl.take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ctrl.take) begin
      done_q  <= res_done;
      arr_q   <= res_arr;
      count_q <= res_count;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_done_o     = done_q;
  assign arrival_0_o      = arr_q[0];
  assign arrival_1_o      = arr_q[1];
  assign arrival_2_o      = arr_q[2];
  assign arrival_3_o      = arr_q[3];
  assign recorded_count_o = count_q;

endmodule

// ----- rtl/mcatc_checker.sv -----
`timescale 1ns / 1ps

module mcatc_checker #(
  parameter int unsigned SENSOR_COUNT = 4,
  parameter int unsigned TIME_BITS    = 48
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           event_done_o,
  input logic [TIME_BITS-1:0]           arrival_0_o,
  input logic [TIME_BITS-1:0]           arrival_1_o,
  input logic [TIME_BITS-1:0]           arrival_2_o,
  input logic [TIME_BITS-1:0]           arrival_3_o,
  input logic [mcatc_pkg::COUNT_W-1:0]  recorded_count_o
);

  localparam logic [mcatc_pkg::COUNT_W-1:0] FULL_COUNT =
    mcatc_pkg::COUNT_W'(SENSOR_COUNT);

  // No result during reset.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_done_o) &&
      $stable(arrival_0_o) && $stable(arrival_1_o) && $stable(arrival_2_o) &&
      $stable(arrival_3_o) && $stable(recorded_count_o))
    else $error("stalled result changed");

  // Done means every sensor is recorded.
  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_done_o |-> recorded_count_o == FULL_COUNT)
    else $error("done with incomplete count");

  // With fewer than eight sensors, an empty store shows no arrival times.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (recorded_count_o == '0) && (SENSOR_COUNT < 8) |->
      (arrival_0_o == '0) && (arrival_1_o == '0) && (arrival_2_o == '0) &&
      (arrival_3_o == '0) && !event_done_o)
    else $error("empty store shows arrival times");

endmodule

bind multi_channel_arrival_time_capture mcatc_checker #(
  .SENSOR_COUNT(SENSOR_COUNT),
  .TIME_BITS   (TIME_BITS)
) u_mcatc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .event_done_o    (event_done_o),
  .arrival_0_o     (arrival_0_o),
  .arrival_1_o     (arrival_1_o),
  .arrival_2_o     (arrival_2_o),
  .arrival_3_o     (arrival_3_o),
  .recorded_count_o(recorded_count_o)
);
